[rtl/lwsc_pkg.sv]
// ----------------------------------------------------------------------------
// lwsc_pkg
// Types and constants shared by the LRU write-back sector cache tag controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lwsc_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned SLOT_W      = 6;
  // a flush lists at most this many dirty slots
  localparam int unsigned LIST_MAX    = 64;
  localparam int unsigned LIST_W      = 7;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [CNT_W-1:0] SAT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] block_addr;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              writeback_needed;
    logic [ADDR_W-1:0] writeback_addr;
    logic              fill_needed;
    logic              last;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  fill_total;
    logic [CNT_W-1:0]  writeback_total;
  } rsp_t;

  // one tag store word
  typedef struct packed {
    logic              dirty;
    logic [ADDR_W-1:0] tag;
    logic [CNT_W-1:0]  stamp;
  } ent_t;

endpackage

`default_nettype wire

[rtl/lwsc_tag_store.sv]
// ----------------------------------------------------------------------------
// lwsc_tag_store
// Tag, stamp and dirty store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lwsc_tag_store #(
  parameter int unsigned Entries = lwsc_pkg::ENTRIES_DEF,
  localparam int unsigned IdxW   = $clog2(Entries)
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire lwsc_pkg::ent_t  wdata_i,
  input  wire logic            re_i,
  input  wire logic [IdxW-1:0] raddr_i,
  output lwsc_pkg::ent_t       rdata_o
);

  lwsc_pkg::ent_t mem_q [Entries];
  lwsc_pkg::ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/lru_writeback_sector_cache_tags.sv]
// ----------------------------------------------------------------------------
// lru_writeback_sector_cache_tags
// Fully associative write-back LRU cache tag and policy controller.
// ----------------------------------------------------------------------------
// read/write: one tag store read per valid slot through one compare unit; the result
//   is registered once the scan ends, and the next request waits until it is issued
// flush: same scan; any request also waits while an earlier result is stalled
// reset: counters and the used-slot count clear at once; slots fill in order and
//   are never invalidated, so that count gives validity with no clear pass
`default_nettype none

module lru_writeback_sector_cache_tags #(
  parameter int unsigned ENTRIES = lwsc_pkg::ENTRIES_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire lwsc_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output lwsc_pkg::rsp_t      out_rsp_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned UseW = $clog2(ENTRIES + 1);
  localparam logic [UseW-1:0] FullCnt = UseW'(ENTRIES);
  localparam logic [lwsc_pkg::LIST_W-1:0] ListMax = lwsc_pkg::LIST_W'(lwsc_pkg::LIST_MAX);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  state_e state_q;
  logic [1:0]                  kind_q;
  logic [lwsc_pkg::ADDR_W-1:0] addr_q;
  logic [UseW-1:0]             used_q;
  logic [UseW-1:0]             ptr_q;
  logic                        rd_vld_q;
  logic [IdxW-1:0]             rd_idx_q;

  logic                        hit_found_q;
  logic [IdxW-1:0]             hit_idx_q;
  logic                        hit_dirty_q;
  logic [lwsc_pkg::CNT_W-1:0]  oldest_q;
  logic [IdxW-1:0]             best_idx_q;
  logic [lwsc_pkg::ADDR_W-1:0] best_tag_q;
  logic                        best_dirty_q;

  logic                        pend_v_q;
  logic [IdxW-1:0]             pend_idx_q;
  logic [lwsc_pkg::ADDR_W-1:0] pend_tag_q;
  logic [lwsc_pkg::LIST_W-1:0] nfound_q;

  logic [lwsc_pkg::CNT_W-1:0]  clock_q, hit_cnt_q, miss_cnt_q, fill_cnt_q, wb_cnt_q;
  logic [lwsc_pkg::CNT_W-1:0]  clock_d, hit_cnt_d, miss_cnt_d, fill_cnt_d, wb_cnt_d;

  logic           out_v_q;
  lwsc_pkg::rsp_t out_rsp_q;

  // tag store ports
  logic            st_we, st_re;
  logic [IdxW-1:0] st_waddr;
  lwsc_pkg::ent_t  st_wdata, st_rdata;

  logic           out_free, is_flush, ent_listed, proc_ok, issue, scan_end, full;
  logic           flush_take, fin_go, wb;
  logic [IdxW-1:0] victim;
  logic           emit_v;
  lwsc_pkg::rsp_t emit_rsp;

  lwsc_tag_store #(
    .Entries(ENTRIES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(ptr_q[IdxW-1:0]),
    .rdata_o(st_rdata)
  );

  assign out_free   = !out_v_q || !out_stall_i;
  assign is_flush   = (kind_q == lwsc_pkg::KIND_FLUSH);
  assign ent_listed = st_rdata.dirty && (nfound_q != ListMax);
  // a flush entry waits if the previous listed slot cannot leave yet
  assign proc_ok    = !rd_vld_q || !(is_flush && ent_listed && pend_v_q && !out_free);
  assign issue      = (state_q == ST_SCAN) && (ptr_q != used_q) && proc_ok;
  assign scan_end   = (state_q == ST_SCAN) && (ptr_q == used_q) && !rd_vld_q;
  assign flush_take = (state_q == ST_SCAN) && rd_vld_q && proc_ok && is_flush && ent_listed;
  assign fin_go     = (state_q == ST_FIN) && out_free;
  assign st_re      = issue;

  assign full   = (used_q == FullCnt);
  assign victim = full ? best_idx_q : used_q[IdxW-1:0];
  assign wb     = !hit_found_q && full && best_dirty_q;

  always_comb begin
    clock_d    = clock_q;
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    fill_cnt_d = fill_cnt_q;
    wb_cnt_d   = wb_cnt_q;
    if (!is_flush) begin
      clock_d = clock_q + 1'b1;
      if (hit_found_q) begin
        if (kind_q == lwsc_pkg::KIND_READ) begin
          hit_cnt_d = hit_cnt_q + 1'b1;
        end
      end else begin
        miss_cnt_d = miss_cnt_q + 1'b1;
        if (fill_cnt_q != lwsc_pkg::SAT_MAX) begin
          fill_cnt_d = fill_cnt_q + 1'b1;
        end
        if (wb) begin
          wb_cnt_d = wb_cnt_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    st_we    = 1'b0;
    st_waddr = rd_idx_q;
    st_wdata = st_rdata;
    if (flush_take) begin
      st_we          = 1'b1;
      st_wdata.dirty = 1'b0;
    end else if (fin_go && !is_flush) begin
      st_we          = 1'b1;
      st_waddr       = hit_found_q ? hit_idx_q : victim;
      st_wdata.tag   = addr_q;
      st_wdata.stamp = clock_d;
      st_wdata.dirty = (kind_q == lwsc_pkg::KIND_WRITE) || (hit_found_q && hit_dirty_q);
    end
  end

  always_comb begin
    emit_v                   = 1'b0;
    emit_rsp.hit             = 1'b0;
    emit_rsp.slot            = lwsc_pkg::SLOT_W'(pend_idx_q);
    emit_rsp.writeback_needed = pend_v_q;
    emit_rsp.writeback_addr  = pend_v_q ? pend_tag_q : '0;
    emit_rsp.fill_needed     = 1'b0;
    emit_rsp.last            = 1'b1;
    emit_rsp.hit_total       = hit_cnt_d;
    emit_rsp.miss_total      = miss_cnt_d;
    emit_rsp.fill_total      = fill_cnt_d;
    emit_rsp.writeback_total = wb_cnt_d;
    if (flush_take) begin
      emit_v        = pend_v_q;
      emit_rsp.last = 1'b0;
    end else if (fin_go) begin
      emit_v = 1'b1;
      if (is_flush) begin
        // nothing dirty gives a single closing result with slot zero and no writeback
        if (!pend_v_q) begin
          emit_rsp.slot = '0;
        end
      end else begin
        emit_rsp.hit              = hit_found_q;
        emit_rsp.slot             = lwsc_pkg::SLOT_W'(hit_found_q ? hit_idx_q : victim);
        emit_rsp.writeback_needed = wb;
        emit_rsp.writeback_addr   = wb ? best_tag_q : '0;
        emit_rsp.fill_needed      = !hit_found_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      hit_found_q <= 1'b0;
      pend_v_q    <= 1'b0;
      nfound_q    <= '0;
      clock_q     <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      fill_cnt_q  <= '0;
      wb_cnt_q    <= '0;
      out_v_q     <= 1'b0;
    end else begin
      if (emit_v) begin
        out_v_q   <= 1'b1;
        out_rsp_q <= emit_rsp;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && (in_req_i.kind != lwsc_pkg::KIND_NONE)) begin
            kind_q      <= in_req_i.kind;
            addr_q      <= in_req_i.block_addr;
            ptr_q       <= '0;
            rd_vld_q    <= 1'b0;
            hit_found_q <= 1'b0;
            pend_v_q    <= 1'b0;
            nfound_q    <= '0;
            state_q     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            ptr_q    <= ptr_q + 1'b1;
            rd_idx_q <= ptr_q[IdxW-1:0];
            rd_vld_q <= 1'b1;
          end else if (proc_ok) begin
            rd_vld_q <= 1'b0;
          end
          if (rd_vld_q && !is_flush) begin
            if (!hit_found_q && (st_rdata.tag == addr_q)) begin
              hit_found_q <= 1'b1;
              hit_idx_q   <= rd_idx_q;
              hit_dirty_q <= st_rdata.dirty;
            end
            // first slot seeds the minimum search
            if ((rd_idx_q == '0) || (st_rdata.stamp < oldest_q)) begin
              oldest_q     <= st_rdata.stamp;
              best_idx_q   <= rd_idx_q;
              best_tag_q   <= st_rdata.tag;
              best_dirty_q <= st_rdata.dirty;
            end
          end
          if (flush_take) begin
            pend_v_q   <= 1'b1;
            pend_idx_q <= rd_idx_q;
            pend_tag_q <= st_rdata.tag;
            nfound_q   <= nfound_q + 1'b1;
          end
          if (scan_end) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            clock_q    <= clock_d;
            hit_cnt_q  <= hit_cnt_d;
            miss_cnt_q <= miss_cnt_d;
            fill_cnt_q <= fill_cnt_d;
            wb_cnt_q   <= wb_cnt_d;
            if (!is_flush && !hit_found_q && !full) begin
              used_q <= used_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_v_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

[rtl/lwsc_checker.sv]
// ----------------------------------------------------------------------------
// lwsc_checker
// Port-level checks for the LRU write-back sector cache tag controller.
// ----------------------------------------------------------------------------
`default_nettype none

module lwsc_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire lwsc_pkg::req_t in_req_i,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire lwsc_pkg::rsp_t out_rsp_o
);

  // a taken request keeps the input stalled while it is scanned
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_req_i.kind != lwsc_pkg::KIND_NONE) |=> in_stall_o)
    else $error("input not stalled after a request");

  // a stalled transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // a hit never needs disk traffic
  a_hit_no_disk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.hit |-> !out_rsp_o.fill_needed && !out_rsp_o.writeback_needed)
    else $error("hit with fill or writeback");

  // writeback address is zero unless a writeback is reported
  a_wb_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.writeback_needed |-> out_rsp_o.writeback_addr == '0)
    else $error("writeback address without writeback");

  // every fill is counted
  a_fill_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.fill_needed |-> out_rsp_o.fill_total != '0)
    else $error("fill with zero fill total");

endmodule

bind lru_writeback_sector_cache_tags lwsc_checker u_lwsc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_req_i   (in_req_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_rsp_o  (out_rsp_o)
);

`default_nettype wire

[tb/cache_tags_checker.sv]
// ----------------------------------------------------------------------------
// cache_tags_checker
// Watches both channels of the cache tag controller. Every accepted request
// runs through a local tag store with LRU replacement and write-back marks,
// and every accepted response is compared field by field in order.
// ----------------------------------------------------------------------------
module cache_tags_checker
  import lwsc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  req_t in_req_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  rsp_t out_rsp_i,
  output int   err_count_o,
  output int   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = ENTRIES_DEF;

  logic              tag_valid [NSLOT];
  logic              tag_dirty [NSLOT];
  logic [ADDR_W-1:0] tag_addr  [NSLOT];
  logic [CNT_W-1:0]  tag_stamp [NSLOT];
  logic [CNT_W-1:0]  access_clk;
  logic [CNT_W-1:0]  read_hits;
  logic [CNT_W-1:0]  misses;
  logic [CNT_W-1:0]  fills;
  logic [CNT_W-1:0]  victim_wbs;

  rsp_t cache_rsp_q[$];

  function automatic string fmt_rsp(input rsp_t r);
    return $sformatf(
      "hit=%0d slot=%0d wb=%0d wb_addr=%h fill=%0d last=%0d hits=%0d misses=%0d fills=%0d wbs=%0d",
      r.hit, r.slot, r.writeback_needed, r.writeback_addr, r.fill_needed, r.last,
      r.hit_total, r.miss_total, r.fill_total, r.writeback_total);
  endfunction

  task automatic note_mismatch(input string msg);
    err_count_o++;
    if (err_count_o <= 10) begin
      $display("%0t: mismatch: %s", $realtime, msg);
    end
  endtask

  // response fields plus the counter values after the request
  task automatic push_rsp(input rsp_t r);
    r.hit_total       = read_hits;
    r.miss_total      = misses;
    r.fill_total      = fills;
    r.writeback_total = victim_wbs;
    cache_rsp_q.push_back(r);
  endtask

  task automatic apply_cache_request(input req_t req);
    rsp_t r;
    int   found;
    int   best;
    int   last_idx;
    int   listed;
    logic [CNT_W-1:0] oldest;
    r = '0;
    case (req.kind)
      KIND_FLUSH: begin
        last_idx = -1;
        listed   = 0;
        for (int i = 0; i < NSLOT && listed < LIST_MAX; i++) begin
          if (tag_valid[i] && tag_dirty[i]) begin
            last_idx = i;
            listed++;
          end
        end
        if (last_idx < 0) begin
          // nothing dirty: a single empty closing entry
          r.last = 1'b1;
          push_rsp(r);
        end else begin
          for (int i = 0; i <= last_idx; i++) begin
            if (tag_valid[i] && tag_dirty[i]) begin
              tag_dirty[i]       = 1'b0;
              r.slot             = SLOT_W'(i);
              r.writeback_needed = 1'b1;
              r.writeback_addr   = tag_addr[i];
              r.last             = (i == last_idx);
              push_rsp(r);
            end
          end
        end
      end
      KIND_NONE: begin
      end
      default: begin
        found = -1;
        for (int i = 0; i < NSLOT; i++) begin
          if (found < 0 && tag_valid[i] && tag_addr[i] == req.block_addr) found = i;
        end
        if (found >= 0) begin
          if (req.kind == KIND_READ) read_hits++;
          else tag_dirty[found] = 1'b1;
          access_clk++;
          tag_stamp[found] = access_clk;
          r.hit  = 1'b1;
          r.slot = SLOT_W'(found);
          r.last = 1'b1;
          push_rsp(r);
        end else begin
          misses++;
          // first free slot, else first slot with the smallest stamp
          best   = 0;
          oldest = SAT_MAX;
          for (int i = 0; i < NSLOT; i++) begin
            if (found < 0) begin
              if (!tag_valid[i]) found = i;
              else if (tag_stamp[i] < oldest) begin
                oldest = tag_stamp[i];
                best   = i;
              end
            end
          end
          if (found < 0) found = best;
          if (tag_valid[found] && tag_dirty[found]) begin
            r.writeback_needed = 1'b1;
            r.writeback_addr   = tag_addr[found];
            victim_wbs++;
          end
          tag_addr[found]  = req.block_addr;
          tag_valid[found] = 1'b1;
          tag_dirty[found] = (req.kind == KIND_WRITE);
          access_clk++;
          tag_stamp[found] = access_clk;
          if (fills != SAT_MAX) fills++;
          r.slot        = SLOT_W'(found);
          r.fill_needed = 1'b1;
          r.last        = 1'b1;
          push_rsp(r);
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NSLOT; i++) begin
        tag_valid[i] = 1'b0;
        tag_dirty[i] = 1'b0;
        tag_addr[i]  = '0;
        tag_stamp[i] = '0;
      end
      access_clk = '0;
      read_hits  = '0;
      misses     = '0;
      fills      = '0;
      victim_wbs = '0;
      cache_rsp_q.delete();
      outstanding_o = 0;
    end else begin
      // responses first, so a request taken on the same edge queues behind
      if (out_valid_i && !out_stall_i) begin
        if (cache_rsp_q.size() == 0) begin
          note_mismatch($sformatf("response with none pending: %s", fmt_rsp(out_rsp_i)));
        end else begin
          want = cache_rsp_q.pop_front();
          if (out_rsp_i.hit !== want.hit || out_rsp_i.slot !== want.slot ||
              out_rsp_i.writeback_needed !== want.writeback_needed ||
              out_rsp_i.writeback_addr !== want.writeback_addr ||
              out_rsp_i.fill_needed !== want.fill_needed ||
              out_rsp_i.last !== want.last ||
              out_rsp_i.hit_total !== want.hit_total ||
              out_rsp_i.miss_total !== want.miss_total ||
              out_rsp_i.fill_total !== want.fill_total ||
              out_rsp_i.writeback_total !== want.writeback_total) begin
            note_mismatch($sformatf("\n  want %s\n  got  %s", fmt_rsp(want),
                                    fmt_rsp(out_rsp_i)));
          end
        end
      end
      if (in_valid_i && !in_stall_i) apply_cache_request(in_req_i);
      outstanding_o = cache_rsp_q.size();
    end
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives read, write, flush and unused requests into the cache tag controller
// in random bursts while the response side stalls on its own pattern, with
// one long hold-off that backs the block up. The checker does the scoring.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lwsc_pkg::*;

  localparam int RAND_ITEMS = 340;
  localparam int POOL_SIZE  = 100;
  localparam int HOLD_START = 3000;
  localparam int HOLD_LEN   = 500;
  localparam int DRAIN_WAIT = 100;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_req_i    = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  int err_count;
  int outstanding;

  int          burst_left = 0;
  logic [31:0] rx_cycle   = '0;
  int          rx_mode    = 0;
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  lru_writeback_sector_cache_tags u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  cache_tags_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_req_i      (in_req_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_rsp_i     (out_rsp_o),
    .err_count_o   (err_count),
    .outstanding_o (outstanding)
  );

  // offer one transaction, opening a new burst after a gap when one runs out
  task automatic send_req(input logic [1:0] kind, input logic [ADDR_W-1:0] addr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 20);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{kind: kind, block_addr: addr};
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
  endtask

  // response side: a new mode whenever the low byte of rx_cycle is zero, plus one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle[7:0] == 8'd0) rx_mode <= $urandom_range(0, 3);
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
        out_stall_i <= 1'b1;
      end else begin
        case (rx_mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= 1'($urandom_range(0, 1));
          2:       out_stall_i <= ($urandom_range(0, 4) == 0);
          default: out_stall_i <= (rx_cycle[3:0] < 4'd5);
        endcase
      end
    end
  end

  initial begin : stimulus
    int          pick;
    int          span;
    logic [1:0]  kind;
    logic [ADDR_W-1:0] addr;
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    addr_pool[2] = 32'h0000_0001;
    addr_pool[3] = 32'h8000_0000;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(KIND_FLUSH, 32'h1234_5678);  // nothing dirty yet
    send_req(KIND_READ,  32'h0000_0000);  // read miss
    send_req(KIND_READ,  32'h0000_0000);  // read hit
    send_req(KIND_WRITE, 32'h0000_0000);  // write hit marks dirty
    send_req(KIND_WRITE, 32'hFFFF_FFFF);  // write miss, left dirty
    send_req(KIND_READ,  32'h8000_0000);
    send_req(KIND_NONE,  $urandom);       // ignored
    send_req(KIND_NONE,  32'hFFFF_FFFF);
    send_req(KIND_FLUSH, 32'h0000_0000);  // lists two slots
    send_req(KIND_FLUSH, 32'hFFFF_FFFF);  // clean again
    send_req(KIND_WRITE, 32'h0000_0001);
    send_req(KIND_READ,  32'h0000_0001);
    send_req(KIND_READ,  32'h0000_0000);
    send_req(KIND_WRITE, 32'h8000_0000);
    send_req(KIND_READ,  32'hFFFF_FFFE);
    send_req(KIND_FLUSH, 32'h0000_0000);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // small working set first for hits, then more blocks than slots
      span = (n < 120) ? 48 : POOL_SIZE;
      pick = $urandom_range(0, 99);
      if (pick < 55)      kind = KIND_READ;
      else if (pick < 90) kind = KIND_WRITE;
      else if (pick < 96) kind = KIND_FLUSH;
      else                kind = KIND_NONE;
      addr = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, span - 1)];
      send_req(kind, addr);
    end
    in_valid_i <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
